FILE: sv/stack_cpu_core_32bit_assert.svh
// Assertion macros used by the checker of the stack CPU core.
`ifndef STACK_CPU_CORE_32BIT_ASSERT_SVH
`define STACK_CPU_CORE_32BIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SCC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stack cpu check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SCC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stack cpu check failed");

`endif

FILE: sv/scc_pkg.sv
// Package of the stack CPU core: types, codes and constants.
`timescale 1ns / 1ps
`default_nettype none

package scc_pkg;

    // Defaults of the top-level parameters (both must be powers of two)
    localparam int MEM_WORDS_DEF   = 32768;
    localparam int STACK_DEPTH_DEF = 32;

    // Fixed width of the reported program counter
    localparam int PC_OUT_W = 15;

    // Memory-mapped ports
    localparam logic [31:0] PORT_CHAR  = 32'hf000_0000;
    localparam logic [31:0] PORT_READY = 32'hf000_0001;

    // Item operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // Instruction bit positions
    localparam int BIT_LIT   = 31;
    localparam int BIT_RET   = 12;
    localparam int BIT_T2N   = 7;
    localparam int BIT_T2R   = 6;
    localparam int BIT_STORE = 5;

    // Instruction classes (bits 30..29 when not a literal)
    typedef enum logic [1:0] {
        CLS_JUMP  = 2'd0,
        CLS_CJUMP = 2'd1,
        CLS_CALL  = 2'd2,
        CLS_ALU   = 2'd3
    } insn_class_t;

    // Extension field (bits 14..13)
    typedef enum logic [1:0] {
        EXT_NONE   = 2'd0,
        EXT_PEER   = 2'd1,
        EXT_LAUNCH = 2'd2,
        EXT_OUTEN  = 2'd3
    } ext_op_t;

    // ALU operations (bits 11..8)
    typedef enum logic [3:0] {
        ALU_T     = 4'h0,
        ALU_N     = 4'h1,
        ALU_ADD   = 4'h2,
        ALU_AND   = 4'h3,
        ALU_OR    = 4'h4,
        ALU_XOR   = 4'h5,
        ALU_INV   = 4'h6,
        ALU_EQ    = 4'h7,
        ALU_LT    = 4'h8,
        ALU_RSH   = 4'h9,
        ALU_DEC   = 4'ha,
        ALU_R     = 4'hb,
        ALU_FETCH = 4'hc,
        ALU_LSH   = 4'hd,
        ALU_DEPTH = 4'he,
        ALU_ULT   = 4'hf
    } alu_op_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD
    } state_t;

    // Side effects of one step that show up on the result beat
    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_char;
        logic        rx_taken;
        logic        launch_valid;
        logic [1:0]  launch_core;
        logic [29:0] launch_addr;
    } side_t;

    // Control from the execute unit to the sequencer
    typedef struct packed {
        logic  ds_we;
        logic  rs_we;
        logic  mem_we;
        logic  need_load;
        logic  out_en_next;
        side_t side;
    } exec_ctl_t;

    // One result beat
    typedef struct packed {
        logic [PC_OUT_W-1:0] next_pc;
        logic [31:0]         top_value;
        side_t               side;
    } result_t;

endpackage

`default_nettype wire

FILE: sv/stack_cpu_core_32bit.sv
// Top level of the 32-bit two-stack CPU core with its word memory.
`timescale 1ns / 1ps
`default_nettype none

// A step beat fetches memory[pc] from the synchronous main memory (one read port,
// one write port) and executes it in the following cycle. While it executes, the
// next step beat is taken and its fetch is issued at the new pc. Steps therefore
// retire one per cycle while step beats keep arriving and no result is stalled. A
// fetch instruction (ALU operation 0xc) that reads a memory word needs the read
// port a second time and passes through the ST_LOAD state. A load beat writes one
// word and returns its result in the next cycle. It is taken only while no step is
// executing. Results leave through a single output register. While a result beat
// is stalled the core holds, so a stall on the result channel also stalls the item
// channel. MEM_WORDS and STACK_DEPTH must be powers of two. Memory words are
// undefined until loaded; the stacks come out of reset cleared.
module stack_cpu_core_32bit
    import scc_pkg::*;
#(
    parameter int MEM_WORDS   = MEM_WORDS_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // item channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [14:0] load_addr,
    input  logic [31:0] load_data,
    input  logic [7:0]  rx_char,
    input  logic [2:0]  peer_idle,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [14:0] next_pc,
    output logic [31:0] top_value,
    output logic        tx_valid,
    output logic [7:0]  tx_char,
    output logic        rx_taken,
    output logic        launch_valid,
    output logic [1:0]  launch_core,
    output logic [29:0] launch_addr
);

    localparam int MEM_AW = $clog2(MEM_WORDS);
    localparam int SP_W   = $clog2(STACK_DEPTH);

    // Architectural state
    state_t            state_reg, state_next;
    logic [MEM_AW-1:0] pc_reg;
    logic [31:0]       t_reg;
    logic [SP_W-1:0]   dp_reg;
    logic [SP_W-1:0]   rp_reg;
    logic              out_en_reg;
    logic [31:0]       dstack_reg [STACK_DEPTH];
    logic [31:0]       rstack_reg [STACK_DEPTH];

    // Main memory and its read data
    logic [31:0]       main_mem [MEM_WORDS];
    logic [31:0]       mem_rdata_reg;

    // Held or forwarded memory word
    logic              ir_sel_reg, ir_sel_next;
    logic [31:0]       ir_reg, ir_next;

    // Beat inputs kept for the execute cycle
    logic [7:0]        rx_reg;
    logic [2:0]        peer_reg;

    // Result waiting for the second memory read, and the output register
    result_t           pend_reg;
    result_t           out_reg;
    logic              out_valid_reg;

    // Control
    logic              out_free;
    logic              take;
    logic              commit;
    logic              t_load;
    logic              produce;
    result_t           result_new;
    logic [MEM_AW-1:0] rd_addr;
    logic              wr_en;
    logic [MEM_AW-1:0] wr_addr;
    logic [31:0]       wr_data;

    // Execute unit
    logic [31:0]       word;
    logic [31:0]       n_val;
    logic [31:0]       r_val;
    exec_ctl_t         ex_ctl;
    logic [MEM_AW-1:0] ex_npc;
    logic [31:0]       ex_t_next;
    logic [SP_W-1:0]   ex_dp_next;
    logic [SP_W-1:0]   ex_rp_next;
    logic [31:0]       ex_rs_wdata;
    logic [MEM_AW-1:0] ex_mem_addr;

    assign word  = ir_sel_reg ? ir_reg : mem_rdata_reg;
    assign n_val = dstack_reg[dp_reg];
    assign r_val = rstack_reg[rp_reg];

    scc_exec #(
        .MEM_AW (MEM_AW),
        .SP_W   (SP_W)
    ) u_exec (
        .insn      (word),
        .t         (t_reg),
        .n         (n_val),
        .r         (r_val),
        .pc        (pc_reg),
        .dp        (dp_reg),
        .rp        (rp_reg),
        .out_en    (out_en_reg),
        .rx_char   (rx_reg),
        .peer_idle (peer_reg),
        .ctl       (ex_ctl),
        .npc       (ex_npc),
        .t_next    (ex_t_next),
        .dp_next   (ex_dp_next),
        .rp_next   (ex_rp_next),
        .rs_wdata  (ex_rs_wdata),
        .mem_addr  (ex_mem_addr)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign take     = in_valid && !in_stall;

    // Sequencer: next state, memory port and result selection
    always_comb
    begin
        state_next  = state_reg;
        in_stall    = 1'b1;
        commit      = 1'b0;
        t_load      = 1'b0;
        produce     = 1'b0;
        result_new  = '0;
        rd_addr     = pc_reg;
        wr_en       = 1'b0;
        wr_addr     = ex_mem_addr;
        wr_data     = n_val;
        ir_sel_next = 1'b0;
        ir_next     = word;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = !out_free;
                if (in_valid && out_free)
                begin
                    if (operation == OP_LOAD)
                    begin
                        wr_en                = 1'b1;
                        wr_addr              = MEM_AW'(load_addr);
                        wr_data              = load_data;
                        produce              = 1'b1;
                        result_new.next_pc   = PC_OUT_W'(pc_reg);
                        result_new.top_value = t_reg;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC:
            begin
                if (ex_ctl.need_load)
                begin
                    // commit now, second read of the port returns T next cycle
                    commit     = 1'b1;
                    wr_en      = ex_ctl.mem_we;
                    rd_addr    = ex_mem_addr;
                    state_next = ST_LOAD;
                end
                else if (out_free)
                begin
                    commit               = 1'b1;
                    wr_en                = ex_ctl.mem_we;
                    produce              = 1'b1;
                    result_new.next_pc   = PC_OUT_W'(ex_npc);
                    result_new.top_value = ex_t_next;
                    result_new.side      = ex_ctl.side;
                    in_stall             = (operation != OP_STEP);
                    if (in_valid && operation == OP_STEP)
                    begin
                        rd_addr = ex_npc;
                        // fetch of the word being stored this cycle
                        if (ex_ctl.mem_we && ex_mem_addr == ex_npc)
                        begin
                            ir_sel_next = 1'b1;
                            ir_next     = n_val;
                        end
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    ir_sel_next = 1'b1;
                end
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    t_load               = 1'b1;
                    produce              = 1'b1;
                    result_new           = pend_reg;
                    result_new.top_value = word;
                    in_stall             = (operation != OP_STEP);
                    if (!(in_valid && operation == OP_STEP))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
                else
                begin
                    ir_sel_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Architectural registers and stacks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= '0;
            t_reg         <= '0;
            dp_reg        <= '0;
            rp_reg        <= '0;
            out_en_reg    <= 1'b1;
            ir_sel_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < STACK_DEPTH; i++)
            begin
                dstack_reg[i] <= '0;
                rstack_reg[i] <= '0;
            end
        end
        else
        begin
            ir_sel_reg    <= ir_sel_next;
            out_valid_reg <= produce || (out_valid_reg && out_stall);
            if (commit)
            begin
                pc_reg     <= ex_npc;
                t_reg      <= ex_t_next;
                dp_reg     <= ex_dp_next;
                rp_reg     <= ex_rp_next;
                out_en_reg <= ex_ctl.out_en_next;
                if (ex_ctl.ds_we)
                begin
                    dstack_reg[ex_dp_next] <= t_reg;
                end
                if (ex_ctl.rs_we)
                begin
                    rstack_reg[ex_rp_next] <= ex_rs_wdata;
                end
            end
            if (t_load)
            begin
                t_reg <= word;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ir_reg <= ir_next;
        if (take)
        begin
            rx_reg   <= rx_char;
            peer_reg <= peer_idle;
        end
        if (commit)
        begin
            pend_reg.next_pc   <= PC_OUT_W'(ex_npc);
            pend_reg.top_value <= ex_t_next;
            pend_reg.side      <= ex_ctl.side;
        end
        if (produce)
        begin
            out_reg <= result_new;
        end
    end

    // Main memory, read-first
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            main_mem[wr_addr] <= wr_data;
        end
        mem_rdata_reg <= main_mem[rd_addr];
    end

    assign out_valid    = out_valid_reg;
    assign next_pc      = out_reg.next_pc;
    assign top_value    = out_reg.top_value;
    assign tx_valid     = out_reg.side.tx_valid;
    assign tx_char      = out_reg.side.tx_char;
    assign rx_taken     = out_reg.side.rx_taken;
    assign launch_valid = out_reg.side.launch_valid;
    assign launch_core  = out_reg.side.launch_core;
    assign launch_addr  = out_reg.side.launch_addr;

endmodule

`default_nettype wire

FILE: sv/scc_exec.sv
// Execute unit of the stack CPU core: decodes one instruction and computes its effects.
`timescale 1ns / 1ps
`default_nettype none

module scc_exec
    import scc_pkg::*;
#(
    parameter int MEM_AW = $clog2(MEM_WORDS_DEF),
    parameter int SP_W   = $clog2(STACK_DEPTH_DEF)
)
(
    input  logic [31:0]       insn,
    input  logic [31:0]       t,
    input  logic [31:0]       n,
    input  logic [31:0]       r,
    input  logic [MEM_AW-1:0] pc,
    input  logic [SP_W-1:0]   dp,
    input  logic [SP_W-1:0]   rp,
    input  logic              out_en,
    input  logic [7:0]        rx_char,
    input  logic [2:0]        peer_idle,
    output exec_ctl_t         ctl,
    output logic [MEM_AW-1:0] npc,
    output logic [31:0]       t_next,
    output logic [SP_W-1:0]   dp_next,
    output logic [SP_W-1:0]   rp_next,
    output logic [31:0]       rs_wdata,
    output logic [MEM_AW-1:0] mem_addr
);

    logic [MEM_AW-1:0] pc_inc;
    logic [MEM_AW-1:0] target;
    logic [31:0]       res;
    insn_class_t       cls;
    alu_op_t           aop;
    ext_op_t           ext;

    assign pc_inc   = pc + 1'b1;
    assign target   = insn[MEM_AW-1:0];
    assign mem_addr = t[MEM_AW+1:2];
    assign cls      = insn_class_t'(insn[30:29]);
    assign aop      = alu_op_t'(insn[11:8]);
    assign ext      = ext_op_t'(insn[14:13]);

    // Decode and execute
    always_comb
    begin
        ctl             = '0;
        ctl.out_en_next = out_en;
        npc             = pc_inc;
        t_next          = t;
        dp_next         = dp;
        rp_next         = rp;
        rs_wdata        = t;
        res             = t;

        if (insn[BIT_LIT])
        begin
            // literal: push T, load low 31 bits
            dp_next   = dp + 1'b1;
            ctl.ds_we = 1'b1;
            t_next    = {1'b0, insn[30:0]};
        end
        else
        begin
            unique case (cls)
                CLS_JUMP:
                begin
                    npc = target;
                end
                CLS_CJUMP:
                begin
                    t_next  = n;
                    dp_next = dp - 1'b1;
                    if (t == 32'd0)
                    begin
                        npc = target;
                    end
                end
                CLS_CALL:
                begin
                    rp_next   = rp + 1'b1;
                    ctl.rs_we = 1'b1;
                    rs_wdata  = 32'(pc_inc) << 2;
                    npc       = target;
                end
                CLS_ALU:
                begin
                    if (insn[BIT_RET])
                    begin
                        npc = r[MEM_AW+1:2];
                    end

                    case (aop)
                        ALU_T:     res = t;
                        ALU_N:     res = n;
                        ALU_ADD:   res = t + n;
                        ALU_AND:   res = t & n;
                        ALU_OR:    res = t | n;
                        ALU_XOR:   res = t ^ n;
                        ALU_INV:   res = ~t;
                        ALU_EQ:    res = {32{t == n}};
                        ALU_LT:    res = {32{$signed(n) < $signed(t)}};
                        ALU_RSH:   res = n >> t[4:0];
                        ALU_DEC:   res = t - 32'd1;
                        ALU_R:     res = r;
                        ALU_FETCH:
                        begin
                            if (t == PORT_READY)
                            begin
                                res = 32'd1;
                            end
                            else if (t == PORT_CHAR)
                            begin
                                res              = 32'(rx_char);
                                ctl.side.rx_taken = 1'b1;
                            end
                            else
                            begin
                                // word comes from the second memory read
                                res           = 32'd0;
                                ctl.need_load = (ext != EXT_PEER);
                            end
                        end
                        ALU_LSH:   res = n << t[4:0];
                        ALU_DEPTH: res = (32'(rp) << 8) + 32'(dp);
                        ALU_ULT:   res = {32{n < t}};
                        default:   res = t;
                    endcase

                    // stack deltas are signed two-bit fields
                    dp_next   = dp + SP_W'($signed(insn[1:0]));
                    rp_next   = rp + SP_W'($signed(insn[3:2]));
                    ctl.ds_we = insn[BIT_T2N];
                    ctl.rs_we = insn[BIT_T2R];

                    // store N to [T], or to the character port
                    if (insn[BIT_STORE])
                    begin
                        if (t == PORT_CHAR)
                        begin
                            ctl.side.tx_char  = n[7:0];
                            ctl.side.tx_valid = out_en;
                        end
                        else
                        begin
                            ctl.mem_we = 1'b1;
                        end
                    end

                    unique case (ext)
                        EXT_NONE:
                        begin
                        end
                        EXT_PEER:
                        begin
                            res = 32'(peer_idle);
                        end
                        EXT_LAUNCH:
                        begin
                            if (t[31:2] == 30'd0 && t[1:0] != 2'd0)
                            begin
                                ctl.side.launch_valid = 1'b1;
                                ctl.side.launch_core  = t[1:0];
                                ctl.side.launch_addr  = n[31:2];
                            end
                        end
                        EXT_OUTEN:
                        begin
                            ctl.out_en_next = (t == 32'd0);
                        end
                    endcase

                    t_next = res;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: sv/scc_checker.sv
// Port checker of the stack CPU core and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "stack_cpu_core_32bit_assert.svh"

module scc_checker
    import scc_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        operation,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic        tx_valid,
    input wire logic        rx_taken,
    input wire logic        launch_valid,
    input wire logic [1:0]  launch_core,
    input wire logic [29:0] launch_addr
);

    // load beat answers next cycle with no side effects
    `SCC_ASSERT_NEXT(a_load_result, in_valid && !in_stall && operation == OP_LOAD, out_valid && !tx_valid && !rx_taken && !launch_valid)

    // launch needs T in 1..3, which excludes both character port accesses
    `SCC_ASSERT_NOW(a_launch_excl, out_valid && launch_valid, launch_core != 2'd0 && !tx_valid && !rx_taken)

    // no launch leaves core and address at zero
    `SCC_ASSERT_NOW(a_launch_zero, out_valid && !launch_valid, launch_core == 2'd0 && launch_addr == 30'd0)

    // a stalled result beat stays
    `SCC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

endmodule

bind stack_cpu_core_32bit scc_checker u_scc_checker (.*);

`default_nettype wire
